[sv/dvse_pkg.sv]
package dvse_pkg;

  // defaults for the top-level parameters
  localparam int unsigned NumChannelsDefault = 3;
  localparam int unsigned PacketBytesDefault = 18;

  // register map
  localparam logic RegSampleFormat = 1'b0;

  // sample conversion offsets
  localparam logic [24:0] Offset24 = 25'h040_0000;
  localparam logic [24:0] Offset20 = 25'h004_0000;

  // delta magnitude limits, as inclusive signed bounds
  localparam logic signed [25:0] LimOnePos   = 26'sh00_003F;
  localparam logic signed [25:0] LimOneNeg   = -26'sh00_003F;
  localparam logic signed [25:0] LimTwoPos   = 26'sh00_1FFF;
  localparam logic signed [25:0] LimTwoNeg   = -26'sh00_1FFF;
  localparam logic signed [25:0] LimThreePos = 26'sh1F_FFFF;
  localparam logic signed [25:0] LimThreeNeg = -26'sh1F_FFFF;

  // tag bits of the multi-byte codes
  localparam logic [1:0] TagTwo   = 2'b10;
  localparam logic [1:0] TagThree = 2'b11;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one coded sample: up to three bytes, first byte in bits 23..16
  typedef struct packed {
    logic [1:0]  count;
    logic [23:0] bytes;
  } code_t;

endpackage

[sv/delta_varlen_sample_encoder_core.sv]
// channel   | signals                                         | direction
// ----------+-------------------------------------------------+----------
// input     | in_valid_i, in_ready_o, channel_i, sample_word_i | in
// output    | out_valid_o, out_ready_i, code_byte_o,          | out
//           | last_of_item_o, packet_end_o                    |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,   | in/out
//           | pready                                          |
//
// a sample passes through the front stage register and the queue, then the back
// end splits it into its code bytes (1 to 3) and sends one byte per cycle while
// out_ready_i is high; the byte-wide output register sets the sustained rate
// the queue lets the front take new samples while the back end is stalled
// reset clears the per-channel previous samples, byte count and format at once
module delta_varlen_sample_encoder_core import dvse_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = NumChannelsDefault,
  parameter int unsigned PACKET_BYTES  = PacketBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  channel_i,
  input  logic [23:0] sample_word_i,
  // code byte output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  code_byte_o,
  output logic        last_of_item_o,
  output logic        packet_end_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic  sample_format_q;
  logic  cfg_write;
  logic  push_valid, push_ready;
  code_t push_code;
  logic  pop_valid, pop_ready;
  code_t pop_code;

  // register write and readback
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_format_q <= 1'b0;
    end else if (cfg_write && (paddr[2] == RegSampleFormat)) begin
      sample_format_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == RegSampleFormat) ? {31'b0, sample_format_q} : '0;

  // conversion and classification
  dvse_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_format_i(sample_format_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_i      (channel_i),
    .sample_word_i  (sample_word_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_code_o    (push_code)
  );

  // coded samples waiting for the byte sender
  dvse_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i (push_code),
    .rd_valid_o(pop_valid),
    .rd_ready_i(pop_ready),
    .rd_data_o (pop_code)
  );

  // byte serializer and packet count
  dvse_back #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_code_i    (pop_code),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_byte_o   (code_byte_o),
    .last_of_item_o(last_of_item_o),
    .packet_end_o  (packet_end_o)
  );

endmodule

[sv/dvse_front.sv]
module dvse_front import dvse_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = NumChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sample_format_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  channel_i,
  input  logic [23:0] sample_word_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output code_t       push_code_o
);

  localparam int unsigned ChW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic                  s1_valid_q, s1_valid_d;
  logic [ChW-1:0]        s1_ch_q;
  logic signed [24:0]    s1_x_q;
  logic signed [24:0]    prev_q [CHANNEL_COUNT];
  logic signed [24:0]    x_conv;
  logic signed [24:0]    prev_sel;
  logic signed [25:0]    delta;
  logic                  fits_one, fits_two, fits_three;
  logic                  advance, accept, in_range;

  // raw word to signed sample
  always_comb begin
    if (sample_format_i) begin
      x_conv = $signed({5'b0, sample_word_i[23:4]} - Offset20);
    end else begin
      x_conv = $signed({1'b0, sample_word_i} - Offset24);
    end
  end

  assign in_range = 32'(channel_i) < CHANNEL_COUNT;

  // difference against the stored sample of this channel
  assign prev_sel = prev_q[s1_ch_q];
  assign delta    = {s1_x_q[24], s1_x_q} - {prev_sel[24], prev_sel};

  assign fits_one   = (delta >= LimOneNeg) && (delta <= LimOnePos);
  assign fits_two   = (delta >= LimTwoNeg) && (delta <= LimTwoPos);
  assign fits_three = (delta >= LimThreeNeg) && (delta <= LimThreePos);

  // an oversized difference leaves without a queue transfer
  assign advance      = s1_valid_q && (!fits_three || push_ready_i);
  assign push_valid_o = s1_valid_q && fits_three;
  assign in_ready_o   = !s1_valid_q || advance;
  assign accept       = in_valid_i && in_ready_o;

  // byte packing by code length
  always_comb begin
    push_code_o = '0;
    if (fits_one) begin
      push_code_o.count = 2'd1;
      push_code_o.bytes = {1'b0, delta[6:0], 16'h0000};
    end else if (fits_two) begin
      push_code_o.count = 2'd2;
      push_code_o.bytes = {TagTwo, delta[13:8], delta[7:0], 8'h00};
    end else begin
      push_code_o.count = 2'd3;
      push_code_o.bytes = {TagThree, delta[21:16], delta[15:8], delta[7:0]};
    end
  end

  // stage valid
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q  <= x_conv;
      s1_ch_q <= ChW'(channel_i);
    end
  end

  // previous sample per channel, updated as the item leaves the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        prev_q[i] <= '0;
      end
    end else if (advance) begin
      prev_q[s1_ch_q] <= s1_x_q;
    end
  end

endmodule

[sv/dvse_queue.sv]
module dvse_queue import dvse_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  code_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output code_t rd_data_o
);

  code_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push, pop;

  assign wr_ready_o = cnt_q != QueueCntW'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue fill count above depth");

  // fill count goes up on a write without a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill count missed a write");
`endif

endmodule

[sv/dvse_back.sv]
module dvse_back import dvse_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PacketBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  code_t      pop_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] code_byte_o,
  output logic       last_of_item_o,
  output logic       packet_end_o
);

  localparam int unsigned FillW = $clog2(PACKET_BYTES);

  logic             w_valid_q, w_valid_d;
  code_t            w_q, w_d;
  code_t            src;
  logic             src_valid, load;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q;
  logic             last_q, end_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             wrap;

  // the partly sent sample takes priority over the queue head
  assign src_valid   = w_valid_q || pop_valid_i;
  assign src         = w_valid_q ? w_q : pop_code_i;
  assign load        = src_valid && (!out_valid_q || out_ready_i);
  assign pop_ready_o = load && !w_valid_q;
  assign wrap        = fill_q == FillW'(PACKET_BYTES - 1);

  // working register and output register control
  always_comb begin
    w_valid_d   = w_valid_q;
    w_d         = w_q;
    out_valid_d = out_valid_q;
    fill_d      = fill_q;
    if (load) begin
      w_valid_d   = src.count != 2'd1;
      w_d.count   = src.count - 2'd1;
      w_d.bytes   = {src.bytes[15:0], 8'h00};
      out_valid_d = 1'b1;
      fill_d      = wrap ? '0 : fill_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
    end else begin
      w_valid_q   <= w_valid_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (load) begin
      byte_q <= src.bytes[23:16];
      last_q <= src.count == 2'd1;
      end_q  <= wrap;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_byte_o    = byte_q;
  assign last_of_item_o = last_q;
  assign packet_end_o   = end_q;

`ifndef NO_ASSERTIONS
  // queue is only read while no sample is partly sent
  assert property (@(posedge clk_i) disable iff (!rst_ni) w_valid_q |-> !pop_ready_o)
    else $error("queue read while a sample is in progress");

  // last byte flag agrees with the working register draining
  assert property (@(posedge clk_i) disable iff (!rst_ni) load |=> last_q == !w_valid_q)
    else $error("last byte flag out of step with working register");

  // packet end flag and byte count wrap together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && wrap) |=> (end_q && fill_q == '0))
    else $error("packet end not marked on count wrap");
`endif

endmodule

[test/delta_varlen_sample_encoder_core_tb.sv]
module delta_varlen_sample_encoder_core_tb;
  import dvse_pkg::*;

  localparam int unsigned NumCh       = NumChannelsDefault;
  localparam int unsigned PacketBytes = PacketBytesDefault;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseItems   = 50;
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned MaxReports   = 40;
  localparam logic [3:0]  FmtOrder     = 4'b1001;

  // register addresses, one word apart
  localparam logic [2:0] AddrFormat = {RegSampleFormat, 2'b00};
  localparam logic [2:0] AddrSpare  = 3'd4;

  // receiver back-pressure modes
  typedef enum logic [1:0] {RxFull, RxCoin, RxSlow, RxPattern} rx_mode_e;

  typedef struct packed {
    logic [1:0]  ch;
    logic [23:0] word;
  } sample_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       pend;
  } code_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  channel_i = '0;
  logic [23:0] sample_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  code_byte_o;
  logic        last_of_item_o;
  logic        packet_end_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  delta_varlen_sample_encoder_core #(
    .CHANNEL_COUNT(NumCh),
    .PACKET_BYTES(PacketBytes)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .channel_i,
    .sample_word_i,
    .out_valid_o,
    .out_ready_i,
    .code_byte_o,
    .last_of_item_o,
    .packet_end_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending samples and the code bytes they should produce
  sample_item_t sample_q[$];
  code_rec_t    coded_bytes_q[$];

  // encoder mirror state
  logic [24:0]  prev_sample[NumCh];
  int unsigned  packet_fill = 0;
  logic         format_reg = 1'b0;

  // stimulus planning copy of the previous samples
  int           plan_prev[NumCh];
  logic         plan_fmt = 1'b0;

  int unsigned  error_count = 0;
  int unsigned  samples_accepted = 0;
  int unsigned  ignored_cnt = 0;
  int unsigned  oversize_cnt = 0;
  int unsigned  bytes_checked = 0;
  int unsigned  packet_cnt = 0;
  int unsigned  format_settings = 0;

  initial begin
    foreach (prev_sample[i]) prev_sample[i] = '0;
    foreach (plan_prev[i]) plan_prev[i] = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    // keep the log short when something is badly off
    if (error_count <= MaxReports)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // append one code byte and advance the packet byte count
  function automatic void put_code(input logic [7:0] b, input logic last);
    code_rec_t c;
    c.code = b;
    c.last = last;
    packet_fill++;
    if (packet_fill >= PacketBytes) begin
      packet_fill = 0;
      c.pend = 1'b1;
    end else begin
      c.pend = 1'b0;
    end
    coded_bytes_q.push_back(c);
  endfunction

  // convert, take the delta to the channel's last sample and code it
  function automatic void encode_sample(input logic [1:0] ch, input logic [23:0] word);
    logic [24:0]        smp;
    logic signed [25:0] diff;
    logic [25:0]        mag;
    if (ch >= NumCh) begin
      ignored_cnt++;
      return;
    end
    if (format_reg) smp = {5'b0, word[23:4]} - Offset20;
    else smp = {1'b0, word} - Offset24;
    diff = {smp[24], smp} - {prev_sample[ch][24], prev_sample[ch]};
    prev_sample[ch] = smp;
    mag = diff[25] ? 26'(-diff) : 26'(diff);
    if (mag < 26'h40) begin
      put_code({1'b0, diff[6:0]}, 1'b1);
    end else if (mag < 26'h2000) begin
      put_code({TagTwo, diff[13:8]}, 1'b0);
      put_code(diff[7:0], 1'b1);
    end else if (mag < 26'h20_0000) begin
      put_code({TagThree, diff[21:16]}, 1'b0);
      put_code(diff[15:8], 1'b0);
      put_code(diff[7:0], 1'b1);
    end else begin
      oversize_cnt++;
    end
  endfunction

  // sample driver: bursts of transfers separated by random gaps
  int unsigned  burst_left;
  int unsigned  gap_left;
  sample_item_t next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      channel_i     <= '0;
      sample_word_i <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        samples_accepted++;
        encode_sample(channel_i, sample_word_i);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the transfer until it is taken
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (sample_q.size() != 0) begin
        next_item = sample_q.pop_front();
        in_valid_i    <= 1'b1;
        channel_i     <= next_item.ch;
        sample_word_i <= next_item.word;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 :
                        ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
                        $urandom_range(1, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure, the mode is redrawn whenever its random span runs out
  rx_mode_e    stall_mode;
  int unsigned stall_span;
  logic [7:0]  stall_pattern;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      stall_mode    <= RxFull;
      stall_span    <= 0;
      stall_pattern <= 8'h01;
    end else begin
      if (stall_span == 0) begin
        stall_mode    <= rx_mode_e'($urandom_range(0, 3));
        stall_span    <= $urandom_range(16, 96);
        stall_pattern <= 8'($urandom()) | 8'h01;
      end else begin
        stall_span    <= stall_span - 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
      case (stall_mode)
        RxFull: out_ready_i <= 1'b1;
        RxCoin: out_ready_i <= 1'($urandom_range(0, 1));
        RxSlow: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= stall_pattern[0];
      endcase
    end
  end

  // output monitor: each code byte transfer against the oldest prediction
  code_rec_t byte_want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_checked++;
      if (packet_end_o) packet_cnt++;
      if (coded_bytes_q.size() == 0) begin
        report_mismatch("code byte with none pending", code_byte_o, 0);
      end else begin
        byte_want = coded_bytes_q.pop_front();
        if (code_byte_o !== byte_want.code)
          report_mismatch("code_byte", code_byte_o, byte_want.code);
        if (last_of_item_o !== byte_want.last)
          report_mismatch("last_of_item", last_of_item_o, byte_want.last);
        if (packet_end_o !== byte_want.pend)
          report_mismatch("packet_end", packet_end_o, byte_want.pend);
      end
    end
  end

  // register access, setup then access phase
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrFormat) format_reg = data[0];
  endtask

  task automatic apb_check_format();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrFormat;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, format_reg})
      report_mismatch("sample_format readback", prdata, {31'b0, format_reg});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new format with junk in the unused bits, a write to an unmapped slot, readback
  task automatic set_format(input logic fmt);
    apb_write(AddrFormat, ($urandom() & 32'hFFFF_FFFE) | {31'b0, fmt});
    apb_write(AddrSpare, $urandom());
    apb_check_format();
    plan_fmt = fmt;
    format_settings++;
    @(negedge clk_i);
  endtask

  // queue a raw word, tracking the sample it converts to
  task automatic push_word(input int ch, input logic [23:0] w);
    sample_q.push_back('{2'(ch), w});
    if (ch < NumCh)
      plan_prev[ch] = plan_fmt ? int'(w[23:4]) - 'h40000 : int'(w) - 'h400000;
  endtask

  // queue a word whose sample lies d away from the channel's last one, mirrored or clamped to stay in range
  task automatic push_delta(input int ch, input int d);
    int lo, hi, x;
    lo = plan_fmt ? -'h40000 : -'h400000;
    hi = plan_fmt ? 'hBFFFF : 'hBFFFFF;
    x = plan_prev[ch] + d;
    if (x < lo || x > hi) x = plan_prev[ch] - d;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    if (plan_fmt) push_word(ch, 24'((x + 'h40000) << 4) | 24'($urandom_range(0, 15)));
    else push_word(ch, 24'(x + 'h400000));
  endtask

  // idle until every code byte is back, then let the front stage settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || coded_bytes_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int  pick;
    int  ch;
    int  sgn;
    logic fmt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 24-bit format: every code length at its boundaries, both signs
    set_format(1'b0);
    push_delta(0, 0);
    push_delta(0, 'h3F);
    push_delta(0, -'h3F);
    push_delta(0, 'h40);
    push_delta(0, -'h40);
    push_delta(0, 'h1FFF);
    push_delta(0, -'h1FFF);
    push_delta(0, 'h2000);
    push_delta(0, -'h2000);
    push_delta(0, 'h1FFFFF);
    push_delta(0, -'h1FFFFF);
    // too large to code, previous sample still moves
    push_delta(0, 'h200000);
    push_delta(0, -'h200000);
    push_word(1, 24'h000000);
    push_word(1, 24'hFFFFFF);
    // unused channel number must leave everything alone
    push_word(3, 24'hFFFFFF);
    push_word(3, 24'h000000);
    push_delta(1, -1);
    push_delta(1, 1);
    push_delta(2, -'h1FFFFF);
    wait_drained();

    // 20-bit format: extremes of the word, low nibble dropped
    set_format(1'b1);
    push_word(0, 24'h000000);
    push_word(0, 24'hFFFFFF);
    push_word(0, 24'hFFFFF0);
    push_delta(0, -'h40);
    push_delta(0, 'h3F);
    push_word(1, 24'h400000);
    push_word(1, 24'h40000F);
    wait_drained();

    // random phases, mostly codable deltas with some raw words and noise
    for (int p = 0; p < RandPhases; p++) begin
      fmt = (p < 4) ? FmtOrder[p] : 1'($urandom_range(0, 1));
      set_format(fmt);
      for (int i = 0; i < PhaseItems; i++) begin
        pick = $urandom_range(0, 99);
        ch   = $urandom_range(0, NumCh - 1);
        sgn  = ($urandom_range(0, 1) != 0) ? -1 : 1;
        if (pick < 22) push_delta(ch, sgn * int'($urandom_range(0, 'h3F)));
        else if (pick < 45) push_delta(ch, sgn * int'($urandom_range('h40, 'h1FFF)));
        else if (pick < 70) push_delta(ch, sgn * int'($urandom_range('h2000, 'h1FFFFF)));
        else if (pick < 80) push_delta(ch, sgn * int'($urandom_range('h200000, 'h7FFFFF)));
        else if (pick < 95) push_word(ch, 24'($urandom()));
        else push_word(3, 24'($urandom()));
      end
      wait_drained();
    end

    $display("covered %0d samples (%0d on an unused channel, %0d too large to code)",
             samples_accepted, ignored_cnt, oversize_cnt);
    $display("checked %0d code bytes across %0d packet boundaries, %0d format settings",
             bytes_checked, packet_cnt, format_settings);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("timeout with %0d code bytes outstanding", coded_bytes_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
